// ===== sv/ppt_pkg.sv =====
package ppt_pkg;

   localparam int CoefW  = 32;
   localparam int CoordW = 16;
   localparam int ProdW  = 48;
   localparam int SumW   = 50;
   localparam int MagW   = 49;
   localparam int QBits  = 25;
   // wide enough to hold the divisor shifted up by the full quotient width
   localparam int DivW   = MagW + QBits;
   localparam int OutW   = 24;
   localparam int NumRegs = 8;
   localparam int IdxW   = 3;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = 2;
   localparam logic [SumW-1:0] DenOne = SumW'(64'd1 << 24);
   localparam logic [QBits-1:0] PosMax = QBits'(24'h7FFFFF);
   localparam logic [QBits-1:0] NegMax = QBits'(25'h0800000);

   localparam logic [IdxW-1:0] RegNxY = 3'd0;
   localparam logic [IdxW-1:0] RegNxX = 3'd1;
   localparam logic [IdxW-1:0] RegNxC = 3'd2;
   localparam logic [IdxW-1:0] RegNyY = 3'd3;
   localparam logic [IdxW-1:0] RegNyX = 3'd4;
   localparam logic [IdxW-1:0] RegNyC = 3'd5;
   localparam logic [IdxW-1:0] RegDY  = 3'd6;
   localparam logic [IdxW-1:0] RegDX  = 3'd7;

   typedef struct packed {
      logic [MagW-1:0] mag_nx;
      logic [MagW-1:0] mag_ny;
      logic [MagW-1:0] mag_d;
      logic            neg_x;
      logic            neg_y;
      logic            div_zero;
   } work_type;

   typedef struct packed {
      logic [OutW-1:0] out_x;
      logic [OutW-1:0] out_y;
      logic            div_zero;
      logic            saturated;
   } result_type;

   typedef struct packed {
      logic [DivW-1:0] rem_x;
      logic [DivW-1:0] rem_y;
      logic [QBits-1:0] q_x;
      logic [QBits-1:0] q_y;
      logic [MagW-1:0] mag_d;
      logic            neg_x;
      logic            neg_y;
      logic            div_zero;
      logic            over_x;
      logic            over_y;
   } div_stage_type;

endpackage

// ===== sv/ppt_front.sv =====
module ppt_front import ppt_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [IdxW:0]            csr_index,
   input  logic [CoefW-1:0]         csr_data,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic signed [CoordW-1:0] in_x,
   input  logic signed [CoordW-1:0] in_y,
   output logic                     out_valid,
   input  logic                     out_ready,
   output work_type                 out_work
);

   logic signed [CoefW-1:0] coef_ff [NumRegs];
   logic signed [ProdW-1:0] prod_ff [6];
   logic signed [CoefW-1:0] cnx_ff, cny_ff;
   logic s1_valid_ff, s2_valid_ff;
   work_type s2_ff, s2_in;
   logic adv1, adv2;
   logic signed [SumW-1:0] nx, ny, dd;

   assign csr_ready = 1'b1;
   assign adv2 = !s2_valid_ff || out_ready;
   assign adv1 = !s1_valid_ff || adv2;
   assign in_ready = adv1;
   assign out_valid = s2_valid_ff;
   assign out_work = s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0] <= '0;
         coef_ff[1] <= CoefW'(32'h0100_0000);
         coef_ff[2] <= '0;
         coef_ff[3] <= CoefW'(32'h0100_0000);
         coef_ff[4] <= '0;
         coef_ff[5] <= '0;
         coef_ff[6] <= '0;
         coef_ff[7] <= '0;
      end else if (csr_valid && !csr_index[IdxW]) begin
         coef_ff[csr_index[IdxW-1:0]] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= in_valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && in_valid) begin
         prod_ff[0] <= coef_ff[RegNxY] * in_y;
         prod_ff[1] <= coef_ff[RegNxX] * in_x;
         prod_ff[2] <= coef_ff[RegNyY] * in_y;
         prod_ff[3] <= coef_ff[RegNyX] * in_x;
         prod_ff[4] <= coef_ff[RegDY] * in_y;
         prod_ff[5] <= coef_ff[RegDX] * in_x;
         cnx_ff <= coef_ff[RegNxC];
         cny_ff <= coef_ff[RegNyC];
      end
      if (adv2 && s1_valid_ff) s2_ff <= s2_in;
   end

   always_comb begin
      nx = SumW'(prod_ff[0]) + SumW'(prod_ff[1]) + SumW'(cnx_ff);
      ny = SumW'(prod_ff[2]) + SumW'(prod_ff[3]) + SumW'(cny_ff);
      dd = SumW'(prod_ff[4]) + SumW'(prod_ff[5]) + $signed(DenOne);
      s2_in.neg_x = nx[SumW-1] != dd[SumW-1];
      s2_in.neg_y = ny[SumW-1] != dd[SumW-1];
      s2_in.mag_nx = MagW'(nx[SumW-1] ? -nx : nx);
      s2_in.mag_ny = MagW'(ny[SumW-1] ? -ny : ny);
      s2_in.mag_d = MagW'(dd[SumW-1] ? -dd : dd);
      s2_in.div_zero = dd == '0;
   end

endmodule

// ===== sv/ppt_queue.sv =====
module ppt_queue import ppt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  work_type in_work,
   output logic     out_valid,
   input  logic     out_ready,
   output work_type out_work
);

   work_type slot_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ff, rd_ff;
   logic [QueuePtrW:0] count_ff;
   logic push, pop;

   assign in_ready = count_ff != QueuePtrW'(0) + (QueuePtrW+1)'(QueueDepth);
   assign out_valid = count_ff != '0;
   assign out_work = slot_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= in_work;
   end

endmodule

// ===== sv/ppt_back.sv =====
module ppt_back import ppt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  work_type   in_work,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   // one quotient bit per stage, QBits stages plus an operand stage
   div_stage_type st_ff [QBits+1];
   div_stage_type st_in [QBits+1];
   logic [QBits:0] vld_ff;
   logic [QBits:0] adv;
   result_type res_ff, res_in;
   logic res_valid_ff, adv_out;

   assign adv_out = !res_valid_ff || out_ready;
   assign out_valid = res_valid_ff;
   assign out_result = res_ff;

   // a stage moves when it is empty or the stage after it moves
   always_comb begin
      logic go;
      go = adv_out;
      for (int k = QBits; k >= 0; k--) begin
         go = go || !vld_ff[k];
         adv[k] = go;
      end
   end
   assign in_ready = adv[0];

   // stage k resolves quotient bit QBits-k; high bits beyond are an overflow test
   always_comb begin
      logic [DivW-1:0] dk;
      st_in[0] = '0;
      st_in[0].rem_x = DivW'(in_work.mag_nx) << 8;
      st_in[0].rem_y = DivW'(in_work.mag_ny) << 8;
      st_in[0].mag_d = in_work.mag_d;
      st_in[0].neg_x = in_work.neg_x;
      st_in[0].neg_y = in_work.neg_y;
      st_in[0].div_zero = in_work.div_zero;
      st_in[0].over_x = (DivW'(in_work.mag_nx) << 8) >=
                        (DivW'(in_work.mag_d) << QBits) && !in_work.div_zero;
      st_in[0].over_y = (DivW'(in_work.mag_ny) << 8) >=
                        (DivW'(in_work.mag_d) << QBits) && !in_work.div_zero;
      for (int k = 1; k <= QBits; k++) begin
         st_in[k] = st_ff[k-1];
         dk = DivW'(st_ff[k-1].mag_d) << (QBits - k);
         if (st_ff[k-1].rem_x >= dk) begin
            st_in[k].rem_x = st_ff[k-1].rem_x - dk;
            st_in[k].q_x[QBits-k] = 1'b1;
         end
         if (st_ff[k-1].rem_y >= dk) begin
            st_in[k].rem_y = st_ff[k-1].rem_y - dk;
            st_in[k].q_y[QBits-k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k <= QBits; k++) begin
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0] && in_valid) st_ff[0] <= st_in[0];
      for (int k = 1; k <= QBits; k++) begin
         if (adv[k] && vld_ff[k-1]) st_ff[k] <= st_in[k];
      end
   end

   function automatic logic [OutW:0] clamp(input logic [QBits-1:0] q, input logic neg,
                                           input logic over);
      logic [QBits-1:0] r;
      logic s;
      r = q;
      s = 1'b0;
      if (neg) begin
         if (over || q > NegMax) begin
            r = NegMax;
            s = 1'b1;
         end
         r = -r;
      end else if (over || q > PosMax) begin
         r = PosMax;
         s = 1'b1;
      end
      return {s, r[OutW-1:0]};
   endfunction

   always_comb begin
      logic [OutW:0] cx, cy;
      cx = clamp(st_ff[QBits].q_x, st_ff[QBits].neg_x, st_ff[QBits].over_x);
      cy = clamp(st_ff[QBits].q_y, st_ff[QBits].neg_y, st_ff[QBits].over_y);
      res_in.div_zero = st_ff[QBits].div_zero;
      res_in.out_x = st_ff[QBits].div_zero ? '0 : cx[OutW-1:0];
      res_in.out_y = st_ff[QBits].div_zero ? '0 : cy[OutW-1:0];
      res_in.saturated = !st_ff[QBits].div_zero && (cx[OutW] || cy[OutW]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (adv_out) begin
         res_valid_ff <= vld_ff[QBits];
      end
      if (adv_out && vld_ff[QBits]) res_ff <= res_in;
   end

endmodule

// ===== sv/perspective_point_transform.sv =====
// Maps a point (x, y) through a normalized homography held in eight Q8.24
// registers and returns Q15.8 coordinates truncated toward zero, with
// zero-denominator and saturation flags. One point per clock is sustained
// while the response side accepts results. A point passes through two
// multiply/sum stages, a four-entry queue, an operand stage, a 25-stage
// restoring divider with one quotient bit per stage and an output register.
module perspective_point_transform import ppt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // in_x[15:0], in_y[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // out_x[23:0], out_y[47:24]
   output logic [1:0]  rsp_tuser   // div_zero[0], saturated[1]
);

   logic f_valid, f_ready, q_valid, q_ready;
   work_type f_work, q_work;
   result_type res;

   ppt_front u_front (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_x(req_tdata[15:0]), .in_y(req_tdata[31:16]),
      .out_valid(f_valid), .out_ready(f_ready), .out_work(f_work)
   );

   ppt_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_work(f_work),
      .out_valid(q_valid), .out_ready(q_ready), .out_work(q_work)
   );

   ppt_back u_back (
      .clock, .reset, .in_valid(q_valid), .in_ready(q_ready), .in_work(q_work),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_result(res)
   );

   assign rsp_tdata = {res.out_y, res.out_x};
   assign rsp_tuser = {res.saturated, res.div_zero};

endmodule
